// ----- rtl/core/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// shared types and constants of the capacitive charge time sensor
// ----------------------------------------------------------------------------
package cts_pkg;

   // default widths of the tick total and the sample counter
   localparam int COUNT_WIDTH_DEF  = 24;
   localparam int SAMPLE_WIDTH_DEF = 8;

   // fixed widths of register and result fields
   localparam int TIMEOUT_W   = 24;
   localparam int DISCHARGE_W = 16;
   localparam int TOTAL_W     = 24;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 1;

   // reset values of the registers
   localparam int BASE_TIMEOUT = 2000;
   localparam int LOOP_FACTOR  = 310;
   localparam int DISCHARGE_US = 10;
   localparam int TICKS_PER_US = 160;

   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = TIMEOUT_W'(BASE_TIMEOUT * LOOP_FACTOR);
   localparam logic [DISCHARGE_W-1:0] DISCHARGE_RESET = DISCHARGE_W'(DISCHARGE_US * TICKS_PER_US);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_IDX_TIMEOUT   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IDX_DISCHARGE = 1'b1;

   // measurement phases
   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_DISCHARGE = 5'b00010,
      PH_CHARGE    = 5'b00100,
      PH_BOOST     = 5'b01000,
      PH_RELEASE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0]   timeout_ticks;
      logic [DISCHARGE_W-1:0] discharge_ticks;
   } cfg_type;

   typedef struct packed {
      logic               send_level;
      logic               recv_drive_enable;
      logic               recv_drive_level;
      logic               busy_res;
      logic               done_res;
      logic               status;
      logic [TOTAL_W-1:0] count_total;
   } result_type;

endpackage

// ----- rtl/core/cts_csr.sv -----
// ----------------------------------------------------------------------------
// cts_csr
// configuration registers: timeout and discharge length
// ----------------------------------------------------------------------------
module cts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cts_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [cts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cts_pkg::cfg_type                 cfg
);
   import cts_pkg::*;

   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic [TIMEOUT_W-1:0]   timeout_in;
   logic [DISCHARGE_W-1:0] discharge_ff;
   logic [DISCHARGE_W-1:0] discharge_in;
   logic                   wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   always_comb begin
      timeout_in   = timeout_ff;
      discharge_in = discharge_ff;
      if (wr_en) begin
         case (csr_addr)
            CSR_IDX_TIMEOUT:   timeout_in   = TIMEOUT_W'(csr_wdata);
            CSR_IDX_DISCHARGE: discharge_in = csr_wdata[DISCHARGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         discharge_ff <= DISCHARGE_RESET;
      end else begin
         timeout_ff   <= timeout_in;
         discharge_ff <= discharge_in;
      end
   end

   assign cfg.timeout_ticks   = timeout_ff;
   assign cfg.discharge_ticks = discharge_ff;

endmodule

// ----- rtl/core/cts_engine.sv -----
// ----------------------------------------------------------------------------
// cts_engine
// phase sequencer and tick accumulator, one tick per step
// ----------------------------------------------------------------------------
module cts_engine #(
   parameter int COUNT_WIDTH  = cts_pkg::COUNT_WIDTH_DEF,
   parameter int SAMPLE_WIDTH = cts_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    start_req,
   input  logic [SAMPLE_WIDTH-1:0] sample_count,
   input  logic                    pin_level,
   input  cts_pkg::cfg_type        cfg,
   output cts_pkg::result_type     result
);
   import cts_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

   phase_type               phase_ff;
   phase_type               phase_in;
   logic [COUNT_WIDTH-1:0]  tick_total_ff;
   logic [COUNT_WIDTH-1:0]  tick_total_in;
   logic [SAMPLE_WIDTH-1:0] samples_left_ff;
   logic [SAMPLE_WIDTH-1:0] samples_left_in;
   logic [DISCHARGE_W-1:0]  delay_count_ff;
   logic [DISCHARGE_W-1:0]  delay_count_in;

   logic [COUNT_WIDTH-1:0]  total_inc;
   logic [SAMPLE_WIDTH-1:0] samples_dec;
   logic [CMP_W-1:0]        timeout_ext;
   logic                    pin_counts;
   logic                    old_over;
   logic                    new_over;
   logic                    done;
   logic                    stat;

   assign total_inc   = tick_total_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
   assign samples_dec = samples_left_ff - {{(SAMPLE_WIDTH-1){1'b0}}, 1'b1};
   assign timeout_ext = CMP_W'(cfg.timeout_ticks);
   assign pin_counts  = (phase_ff == PH_CHARGE) ? ~pin_level : pin_level;
   assign old_over    = CMP_W'(tick_total_ff) >= timeout_ext;
   assign new_over    = CMP_W'(total_inc) >= timeout_ext;

   always_comb begin
      phase_in        = phase_ff;
      tick_total_in   = tick_total_ff;
      samples_left_in = samples_left_ff;
      delay_count_in  = delay_count_ff;
      done            = 1'b0;
      stat            = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               tick_total_in = '0;
               if (sample_count == '0) begin
                  done = 1'b1;
               end else begin
                  samples_left_in = sample_count;
                  delay_count_in  = cfg.discharge_ticks;
                  phase_in        = PH_DISCHARGE;
               end
            end
         end
         PH_DISCHARGE: begin
            if (delay_count_ff <= DISCHARGE_W'(1)) begin
               phase_in = PH_CHARGE;
            end else begin
               delay_count_in = delay_count_ff - DISCHARGE_W'(1);
            end
         end
         PH_CHARGE, PH_RELEASE: begin
            if (old_over) begin
               done     = 1'b1;
               stat     = 1'b1;
               phase_in = PH_IDLE;
            end else if (pin_counts) begin
               tick_total_in = total_inc;
               if (new_over) begin
                  done     = 1'b1;
                  stat     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end else if (phase_ff == PH_CHARGE) begin
               phase_in = PH_BOOST;
            end else begin
               samples_left_in = samples_dec;
               if (samples_dec == '0) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  delay_count_in = cfg.discharge_ticks;
                  phase_in       = PH_DISCHARGE;
               end
            end
         end
         PH_BOOST: phase_in = PH_RELEASE;
         default:  phase_in = PH_IDLE;
      endcase
   end

   // pin levels follow the phase at the start of the tick
   always_comb begin
      result                   = '0;
      result.send_level        = (phase_ff == PH_CHARGE) | (phase_ff == PH_BOOST);
      result.recv_drive_enable = (phase_ff == PH_DISCHARGE) | (phase_ff == PH_BOOST);
      result.recv_drive_level  = (phase_ff == PH_BOOST);
      result.busy_res          = (phase_ff != PH_IDLE);
      result.done_res          = done;
      result.status            = stat;
      result.count_total       = done ? TOTAL_W'(tick_total_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_total_ff   <= '0;
         samples_left_ff <= '0;
         delay_count_ff  <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         tick_total_ff   <= tick_total_in;
         samples_left_ff <= samples_left_in;
         delay_count_ff  <= delay_count_in;
      end
   end

   a_timeout_only_when_counting: assert property (@(posedge clock) disable iff (reset)
      step_en && result.status |-> (phase_ff == PH_CHARGE || phase_ff == PH_RELEASE))
      else $error("timeout status outside a counting phase");

   a_boost_one_tick: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_BOOST |=> phase_ff == PH_RELEASE)
      else $error("boost did not move to release");

   a_discharge_keeps_total: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_DISCHARGE |=> $stable(tick_total_ff))
      else $error("total changed during discharge");

   a_idle_without_start: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_IDLE && !start_req |=> phase_ff == PH_IDLE)
      else $error("left idle without a start");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done_res |=> phase_ff == PH_IDLE)
      else $error("run still busy after done");

endmodule

// ----- rtl/core/capacitive_charge_time_sensor_top.sv -----
// ----------------------------------------------------------------------------
// capacitive_charge_time_sensor_top
// charge time measurement for a capacitive touch pad, one item per tick
// ----------------------------------------------------------------------------
// each req item is one tick of the sampled receive pin, with a start flag and
// a sample count that is taken when a run starts from idle
// each req item yields exactly one rsp item: the pin drive levels for that
// tick, busy, and on the tick a run ends done (tlast), status and the total
// csr writes set the timeout and the discharge length; they are meant for
// idle periods only and take effect on the next tick
// datapath: input register, one pass of phase and counter logic, result
// register; the phase state advances as an item moves to the result register
// an item's result is loaded into the result register as the item leaves the
// input register, and rsp shows it from then on until the receiver takes it
// throughput: one item per cycle sustained while rsp_tready is high
// receiver stall: the result register holds, the input register still takes
// one more item, and req_tready falls only when both are full
// reset: synchronous, clears both registers' valid flags and the phase state;
// timeout returns to 620000 ticks and discharge to 1600 ticks
// ----------------------------------------------------------------------------
module capacitive_charge_time_sensor_top #(
   parameter int COUNT_WIDTH  = cts_pkg::COUNT_WIDTH_DEF,
   parameter int SAMPLE_WIDTH = cts_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // start_req [0], sample_count, pin_level, zero fill
   input  logic [((SAMPLE_WIDTH+2+7)/8)*8-1:0] req_tdata,

   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // send_level [0], recv_drive_enable [1], recv_drive_level [2],
   // busy_res [3], status [4], count_total [28:5], zero fill
   output logic [31:0]                    rsp_tdata,
   output logic                           rsp_tlast,    // done_res

   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cts_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cts_pkg::*;

   cfg_type    cfg;
   result_type step_result;

   // input register
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic                    in_start_ff;
   logic [SAMPLE_WIDTH-1:0] in_samples_ff;
   logic                    in_pin_ff;

   // result register
   logic                    out_valid_ff;
   logic                    out_valid_in;
   result_type              out_result_ff;

   logic                    req_fire;
   logic                    advance;

   // item moves forward when the result register is free or being emptied
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_start_ff   <= req_tdata[0];
         in_samples_ff <= req_tdata[SAMPLE_WIDTH:1];
         in_pin_ff     <= req_tdata[SAMPLE_WIDTH+1];
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   cts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cts_engine #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .start_req    (in_start_ff),
      .sample_count (in_samples_ff),
      .pin_level    (in_pin_ff),
      .cfg          (cfg),
      .result       (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_result_ff.done_res;
   assign rsp_tdata  = {3'b000,
                        out_result_ff.count_total,
                        out_result_ff.status,
                        out_result_ff.busy_res,
                        out_result_ff.recv_drive_level,
                        out_result_ff.recv_drive_enable,
                        out_result_ff.send_level};

endmodule
